// File: hw/rtl/rle8bd_pkg.sv
// Shared types and constants for the RLE8 bitmap decoder.
package rle8bd_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int DIM_LIMIT = 4096;

   localparam int CFG_DIM_W = 13;
   localparam int ROW_W     = 12;
   localparam int COL_W     = 12;
   localparam int BYTE_W    = 8;
   localparam int CURSOR_W  = 16;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BOTTOM_UP    = 2'd2;

   localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 13'd256;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 13'd256;
   localparam logic                 BOTTOM_UP_RESET = 1'b1;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_DIM_W-1:0] image_height;
      logic                 bottom_up;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  start_column;
      logic [BYTE_W-1:0] run_length;
      logic [BYTE_W-1:0] pixel_index;
      logic              finished;
   } result_type;

endpackage

// File: hw/rtl/rle8_bitmap_decoder_top.sv
// Top level of the RLE8 bitmap decoder: configuration, parser and result register.
//
// The req channel takes one byte of an 8-bit run-length coded bitmap per item,
// with req_final_byte set on the last byte of an image. The rsp channel gives
// at most one item per input byte: a pixel run (row, start column, length and
// palette index) or, on the final byte, an item with rsp_finished set that
// also carries any run that byte causes. Bytes that cause no run give nothing.
// Image width, height and the bottom-up flag are set through the APB-style port,
// by the user only while no item is in flight, as the block does not enforce it;
// writes to unused addresses are ignored. A result is registered and appears on
// rsp the cycle after its byte is accepted. One byte can be accepted every cycle,
// limited only by the single result register; req_stall rises when that register
// is full and rsp_stall is high, and the pending result is then held unchanged.
// Reset returns the parser to its start state, empties the result register
// and loads the registers with width 256, height 256 and bottom-up set.
// After a final byte the parser returns to its start state by itself.
module rle8_bitmap_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_code_byte,
   input  logic                          req_final_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [11:0]                   rsp_out_row,
   output logic [11:0]                   rsp_start_column,
   output logic [7:0]                    rsp_run_length,
   output logic [7:0]                    rsp_pixel_index,
   output logic                          rsp_finished,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rle8bd_pkg::ADDR_W-1:0] paddr,
   input  logic [rle8bd_pkg::DATA_W-1:0] pwdata,
   output logic [rle8bd_pkg::DATA_W-1:0] prdata,
   output logic                          pready
);
   import rle8bd_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data;
   logic       has_result;
   logic       space;
   logic       accept;

   assign req_stall = !space;
   assign accept    = req_valid && space;

   rle8bd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rle8bd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .code_byte  (req_code_byte),
      .final_byte (req_final_byte),
      .has_result (has_result),
      .result     (result)
   );

   rle8bd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && has_result),
      .result    (result),
      .rsp_stall (rsp_stall),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_row      = rsp_data.out_row;
   assign rsp_start_column = rsp_data.start_column;
   assign rsp_run_length   = rsp_data.run_length;
   assign rsp_pixel_index  = rsp_data.pixel_index;
   assign rsp_finished     = rsp_data.finished;

endmodule

// File: hw/rtl/rle8bd_csr.sv
// Configuration registers of the RLE8 bitmap decoder behind an APB-style port.
module rle8bd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rle8bd_pkg::ADDR_W-1:0] paddr,
   input  logic [rle8bd_pkg::DATA_W-1:0] pwdata,
   output logic [rle8bd_pkg::DATA_W-1:0] prdata,
   output logic                          pready,
   output rle8bd_pkg::cfg_type           cfg
);
   import rle8bd_pkg::*;

   logic [CFG_DIM_W-1:0] image_width_ff, image_width_in;
   logic [CFG_DIM_W-1:0] image_height_ff, image_height_in;
   logic                 bottom_up_ff, bottom_up_in;
   logic                 wr_en;
   logic [1:0]           reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      bottom_up_in    = bottom_up_ff;
      if (wr_en) begin
         case (reg_index)
            REG_IMAGE_WIDTH:  image_width_in  = pwdata[CFG_DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_in = pwdata[CFG_DIM_W-1:0];
            REG_BOTTOM_UP:    bottom_up_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_IMAGE_WIDTH:  prdata = {{(DATA_W-CFG_DIM_W){1'b0}}, image_width_ff};
         REG_IMAGE_HEIGHT: prdata = {{(DATA_W-CFG_DIM_W){1'b0}}, image_height_ff};
         REG_BOTTOM_UP:    prdata = {{(DATA_W-1){1'b0}}, bottom_up_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         bottom_up_ff    <= BOTTOM_UP_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         bottom_up_ff    <= bottom_up_in;
      end
   end

   assign cfg.image_width  = image_width_ff;
   assign cfg.image_height = image_height_ff;
   assign cfg.bottom_up    = bottom_up_ff;

endmodule

// File: hw/rtl/rle8bd_parse.sv
// Parse state of the RLE8 stream and the write decision for each accepted byte.
module rle8bd_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  rle8bd_pkg::cfg_type           cfg,
   input  logic                          accept,
   input  logic [rle8bd_pkg::BYTE_W-1:0] code_byte,
   input  logic                          final_byte,
   output logic                          has_result,
   output rle8bd_pkg::result_type        result
);
   import rle8bd_pkg::*;

   typedef enum logic [6:0] {
      PH_COUNT   = 7'b0000001,
      PH_VALUE   = 7'b0000010,
      PH_DELTA_X = 7'b0000100,
      PH_DELTA_Y = 7'b0001000,
      PH_LITERAL = 7'b0010000,
      PH_PAD     = 7'b0100000,
      PH_STOPPED = 7'b1000000
   } phase_type;

   localparam logic [BYTE_W-1:0] ESC_END_LINE   = 8'd0;
   localparam logic [BYTE_W-1:0] ESC_END_BITMAP = 8'd1;
   localparam logic [BYTE_W-1:0] ESC_DELTA      = 8'd2;

   localparam int WIDTH_CAP_I = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
   localparam logic [CFG_DIM_W-1:0] WIDTH_CAP  = CFG_DIM_W'(WIDTH_CAP_I);
   localparam logic [CFG_DIM_W-1:0] HEIGHT_CAP = CFG_DIM_W'(DIM_LIMIT);

   function automatic logic [CURSOR_W-1:0] sat_add(input logic [CURSOR_W-1:0] a,
                                                   input logic [CURSOR_W-1:0] b);
      logic [CURSOR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CURSOR_W] ? {CURSOR_W{1'b1}} : s[CURSOR_W-1:0];
   endfunction

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    held_ff, held_in;
   logic [BYTE_W-1:0]    lit_ff, lit_in;
   logic                 pad_ff, pad_in;
   logic [CURSOR_W-1:0]  col_ff, col_in;
   logic [CURSOR_W-1:0]  row_ff, row_in;

   logic [CFG_DIM_W-1:0] eff_w, eff_h;
   logic                 col_ok, row_ok;
   logic [CFG_DIM_W-1:0] room;
   logic [BYTE_W-1:0]    run_len;
   logic                 write;
   logic [CFG_DIM_W-1:0] row_flip;

   assign eff_w  = (cfg.image_width > WIDTH_CAP) ? WIDTH_CAP : cfg.image_width;
   assign eff_h  = (cfg.image_height > HEIGHT_CAP) ? HEIGHT_CAP : cfg.image_height;
   assign col_ok = col_ff < {{(CURSOR_W-CFG_DIM_W){1'b0}}, eff_w};
   assign row_ok = row_ff < {{(CURSOR_W-CFG_DIM_W){1'b0}}, eff_h};
   // Only meaningful while the column is inside the width.
   assign room   = eff_w - col_ff[CFG_DIM_W-1:0];
   assign run_len = ({{(CFG_DIM_W-BYTE_W){1'b0}}, held_ff} < room) ? held_ff
                                                                    : room[BYTE_W-1:0];
   assign row_flip = eff_h - CFG_DIM_W'(1) - row_ff[CFG_DIM_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      lit_in   = lit_ff;
      pad_in   = pad_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      write    = 1'b0;
      result   = '0;
      case (phase_ff)
         PH_COUNT: begin
            if (!row_ok) begin
               phase_in = PH_STOPPED;
            end else begin
               held_in  = code_byte;
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            phase_in = PH_COUNT;
            if (held_ff != '0) begin
               if (col_ok) begin
                  write                = 1'b1;
                  result.start_column  = col_ff[COL_W-1:0];
                  result.run_length    = run_len;
                  result.pixel_index   = code_byte;
                  col_in = col_ff + {{(CURSOR_W-BYTE_W){1'b0}}, run_len};
               end
            end else if (code_byte == ESC_END_LINE) begin
               col_in = '0;
               row_in = sat_add(row_ff, CURSOR_W'(1));
            end else if (code_byte == ESC_END_BITMAP) begin
               phase_in = PH_STOPPED;
            end else if (code_byte == ESC_DELTA) begin
               phase_in = PH_DELTA_X;
            end else begin
               lit_in   = code_byte;
               pad_in   = code_byte[0];
               phase_in = PH_LITERAL;
            end
         end
         PH_DELTA_X: begin
            held_in  = code_byte;
            phase_in = PH_DELTA_Y;
         end
         PH_DELTA_Y: begin
            col_in   = sat_add(col_ff, {{(CURSOR_W-BYTE_W){1'b0}}, held_ff});
            row_in   = sat_add(row_ff, {{(CURSOR_W-BYTE_W){1'b0}}, code_byte});
            phase_in = PH_COUNT;
         end
         PH_LITERAL: begin
            if (col_ok && row_ok) begin
               write               = 1'b1;
               result.start_column = col_ff[COL_W-1:0];
               result.run_length   = BYTE_W'(1);
               result.pixel_index  = code_byte;
            end
            col_in = sat_add(col_ff, CURSOR_W'(1));
            lit_in = lit_ff - BYTE_W'(1);
            if (lit_in == '0) begin
               phase_in = pad_ff ? PH_PAD : PH_COUNT;
            end
         end
         PH_PAD: begin
            pad_in   = 1'b0;
            phase_in = PH_COUNT;
         end
         default: begin
            phase_in = PH_STOPPED;
         end
      endcase

      // A write only happens with the row inside the height, so both forms fit.
      if (write) begin
         result.out_row = cfg.bottom_up ? row_flip[ROW_W-1:0] : row_ff[ROW_W-1:0];
      end
      result.finished = final_byte;

      if (final_byte) begin
         phase_in = PH_COUNT;
         held_in  = '0;
         lit_in   = '0;
         pad_in   = 1'b0;
         col_in   = '0;
         row_in   = '0;
      end
   end

   assign has_result = write || final_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         held_ff  <= '0;
         lit_ff   <= '0;
         pad_ff   <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         lit_ff   <= lit_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

`ifndef SYNTH
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && final_byte |=> phase_ff == PH_COUNT && col_ff == '0 && row_ff == '0)
      else $error("final item did not return the parser to its start state");

   a_literal_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LITERAL |-> lit_ff != '0)
      else $error("literal phase entered with no literal bytes left");

   a_write_has_length: assert property (@(posedge clock) disable iff (reset)
      has_result && !final_byte |-> result.run_length != '0)
      else $error("result without a final flag carries no pixels");
`endif

endmodule

// File: hw/rtl/rle8bd_out.sv
// Result register of the RLE8 bitmap decoder, held while the receiver stalls.
module rle8bd_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rle8bd_pkg::result_type result,
   input  logic                   rsp_stall,
   output logic                   space,
   output logic                   rsp_valid,
   output rle8bd_pkg::result_type rsp_data
);
   import rle8bd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register can take a new item when it is empty or being emptied now.
   assign space = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

`ifndef SYNTH
   a_finish_delivered: assert property (@(posedge clock) disable iff (reset)
      load && result.finished |=> valid_ff && data_ff.finished)
      else $error("final result was not registered");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the RLE8 bitmap decoder, with its own decoder predictor.
`timescale 1ns / 1ps

module tb_top;
   import rle8bd_pkg::*;

   localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
   localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
   localparam logic [7:0] ESC_DELTA         = 8'd2;

   typedef enum logic [2:0] {
      EXPECT_COUNT, EXPECT_VALUE, EXPECT_DX, EXPECT_DY, IN_LITERAL, EXPECT_PAD, HALTED
   } parse_state_type;

   typedef struct packed {
      logic [7:0] code;
      logic       fin;
      logic       hold;
   } coded_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_code_byte = 8'd0;
   logic                req_final_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [11:0]         rsp_out_row;
   logic [11:0]         rsp_start_column;
   logic [7:0]          rsp_run_length;
   logic [7:0]          rsp_pixel_index;
   logic                rsp_finished;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Register copies and decoder state of the predictor.
   logic [CFG_DIM_W-1:0] cfg_width = WIDTH_RESET;
   logic [CFG_DIM_W-1:0] cfg_height = HEIGHT_RESET;
   logic                 cfg_bottom_up = BOTTOM_UP_RESET;
   parse_state_type      parse_state = EXPECT_COUNT;
   logic [7:0]           held_count = 8'd0;
   logic [7:0]           literals_left = 8'd0;
   logic                 pad_pending = 1'b0;
   logic [15:0]          col_cursor = 16'd0;
   logic [15:0]          row_cursor = 16'd0;

   coded_byte_type stream_bytes[$];
   result_type     expected_writes[$];

   int errors = 0;
   int bytes_queued = 0;
   int bytes_sent = 0;
   int images_queued = 0;
   int settings_used = 1;
   int results_seen = 0;
   int runs_seen = 0;
   int holds_done = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   rle8_bitmap_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_row      (rsp_out_row),
      .rsp_start_column (rsp_start_column),
      .rsp_run_length   (rsp_run_length),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_finished     (rsp_finished),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Advances the decoder state by one coded byte; returns 1 when the byte gives a result.
   function automatic bit decode_byte(input logic [7:0] code, input logic fin,
                                      output result_type res);
      int  w, h, room, len, col, row;
      bit  wr;
      w = cfg_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (w > DIM_LIMIT) w = DIM_LIMIT;
      h = cfg_height;
      if (h > DIM_LIMIT) h = DIM_LIMIT;
      wr = 1'b0;
      len = 0;
      col = 0;
      row = 0;
      res = '0;
      case (parse_state)
         EXPECT_COUNT: begin
            if (row_cursor >= h) begin
               parse_state = HALTED;
            end else begin
               held_count = code;
               parse_state = EXPECT_VALUE;
            end
         end
         EXPECT_VALUE: begin
            parse_state = EXPECT_COUNT;
            if (held_count != 8'd0) begin
               if (col_cursor < w) begin
                  room = w - col_cursor;
                  len = (held_count < room) ? held_count : room;
                  col = col_cursor;
                  res.pixel_index = code;
                  wr = 1'b1;
                  col_cursor = col_cursor + len[15:0];
               end
            end else if (code == ESC_END_OF_LINE) begin
               col_cursor = 16'd0;
               row_cursor = add_sat(row_cursor, 16'd1);
            end else if (code == ESC_END_OF_BITMAP) begin
               parse_state = HALTED;
            end else if (code == ESC_DELTA) begin
               parse_state = EXPECT_DX;
            end else begin
               literals_left = code;
               pad_pending = code[0];
               parse_state = IN_LITERAL;
            end
         end
         EXPECT_DX: begin
            held_count = code;
            parse_state = EXPECT_DY;
         end
         EXPECT_DY: begin
            col_cursor = add_sat(col_cursor, {8'd0, held_count});
            row_cursor = add_sat(row_cursor, {8'd0, code});
            parse_state = EXPECT_COUNT;
         end
         IN_LITERAL: begin
            if (col_cursor < w && row_cursor < h) begin
               col = col_cursor;
               len = 1;
               res.pixel_index = code;
               wr = 1'b1;
            end
            col_cursor = add_sat(col_cursor, 16'd1);
            literals_left = literals_left - 8'd1;
            if (literals_left == 8'd0) parse_state = pad_pending ? EXPECT_PAD : EXPECT_COUNT;
         end
         EXPECT_PAD: begin
            pad_pending = 1'b0;
            parse_state = EXPECT_COUNT;
         end
         default: parse_state = HALTED;
      endcase
      if (wr) begin
         row = cfg_bottom_up ? (h - 1 - row_cursor) : row_cursor;
         res.out_row = row[11:0];
         res.start_column = col[11:0];
         res.run_length = len[7:0];
      end else begin
         res.pixel_index = 8'd0;
      end
      res.finished = fin;
      if (fin) begin
         parse_state = EXPECT_COUNT;
         held_count = 8'd0;
         literals_left = 8'd0;
         pad_pending = 1'b0;
         col_cursor = 16'd0;
         row_cursor = 16'd0;
      end
      return wr || fin;
   endfunction

   // Sender: bursts of items with gaps between them, and an optional wait for an empty pipeline.
   always @(posedge clock) begin : send_bytes
      result_type     res;
      coded_byte_type item;
      logic           next_valid;
      logic [7:0]     next_code;
      logic           next_fin;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes_sent++;
            if (decode_byte(req_code_byte, req_final_byte, res)) expected_writes.push_back(res);
         end
         if (!(req_valid && req_stall)) begin
            next_valid = 1'b0;
            next_code = 8'($urandom);
            next_fin = 1'($urandom);
            if (gap_left > 0) begin
               gap_left--;
            end else if (stream_bytes.size() != 0 &&
                         !(stream_bytes[0].hold && expected_writes.size() != 0)) begin
               item = stream_bytes.pop_front();
               if (item.hold) holds_done++;
               next_valid = 1'b1;
               next_code = item.code;
               next_fin = item.fin;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= next_valid;
            req_code_byte <= next_code;
            req_final_byte <= next_fin;
         end
      end
   end

   // Receiver: checks each accepted item against the oldest expectation and stalls on its own pattern.
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      logic       next_stall;
      cycle_count++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_row, rsp_start_column, rsp_run_length, rsp_pixel_index, rsp_finished};
            results_seen++;
            if (expected_writes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result row %0d col %0d len %0d idx %0d fin %0b",
                           $realtime, got.out_row, got.start_column, got.run_length,
                           got.pixel_index, got.finished);
            end else begin
               want = expected_writes.pop_front();
               if (want.run_length != 8'd0) runs_seen++;
               if (got.out_row !== want.out_row || got.start_column !== want.start_column ||
                   got.run_length !== want.run_length || got.pixel_index !== want.pixel_index ||
                   got.finished !== want.finished) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: result row %0d col %0d len %0d idx %0d fin %0b, %s %0d %0d %0d %0d %0b",
                              $realtime, got.out_row, got.start_column, got.run_length,
                              got.pixel_index, got.finished, "expected",
                              want.out_row, want.start_column, want.run_length,
                              want.pixel_index, want.finished);
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: next_stall = 1'b0;
            1: next_stall = ($urandom_range(0, 3) == 0);
            2: next_stall = ($urandom_range(0, 3) != 0);
            default: next_stall = (cycle_count % 3 == 0);
         endcase
         rsp_stall <= next_stall;
      end
   end

   task automatic csr_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_settings();
      logic [1:0]  regs[3];
      logic [31:0] got;
      logic [31:0] want;
      regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BOTTOM_UP};
      foreach (regs[i]) begin
         csr_access(regs[i], 1'b0, 32'd0, got);
         case (regs[i])
            REG_IMAGE_WIDTH:  want = {19'd0, cfg_width};
            REG_IMAGE_HEIGHT: want = {19'd0, cfg_height};
            default:          want = {31'd0, cfg_bottom_up};
         endcase
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: register %0d reads %0h, expected %0h", $realtime, regs[i], got, want);
         end
      end
   endtask

   // Writes all three registers with junk in the unused upper bits, then reads them back.
   task automatic apply_settings(input logic [12:0] w, input logic [12:0] h, input logic bu);
      logic [31:0] junk;
      logic [31:0] unused;
      junk = $urandom;
      csr_access(REG_IMAGE_WIDTH, 1'b1, {junk[31:CFG_DIM_W], w}, unused);
      cfg_width = w;
      junk = $urandom;
      csr_access(REG_IMAGE_HEIGHT, 1'b1, {junk[31:CFG_DIM_W], h}, unused);
      cfg_height = h;
      junk = $urandom;
      csr_access(REG_BOTTOM_UP, 1'b1, {junk[31:1], bu}, unused);
      cfg_bottom_up = bu;
      settings_used++;
      check_settings();
   endtask

   task automatic push_code(input logic [7:0] code, input logic fin);
      stream_bytes.push_back({code, fin, 1'b0});
      bytes_queued++;
      if (fin) images_queued++;
   endtask

   // One image: mostly well-formed runs and escapes with random content, sometimes pure noise.
   task automatic queue_image(input bit hold_first);
      coded_byte_type img[$];
      int             n_ops, pick, n;
      logic [7:0]     b;
      n_ops = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 16);
         repeat (n) img.push_back({8'($urandom), 2'b00});
      end else begin
         for (int op = 0; op < n_ops; op++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               b = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 12));
               img.push_back({b, 2'b00});
               img.push_back({8'($urandom), 2'b00});
            end else if (pick < 55) begin
               img.push_back({8'd0, 2'b00});
               img.push_back({ESC_END_OF_LINE, 2'b00});
            end else if (pick < 65) begin
               img.push_back({8'd0, 2'b00});
               img.push_back({ESC_DELTA, 2'b00});
               b = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 8));
               img.push_back({b, 2'b00});
               b = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 2));
               img.push_back({b, 2'b00});
            end else if (pick < 85) begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 20);
               img.push_back({8'd0, 2'b00});
               img.push_back({8'(n), 2'b00});
               repeat (n + (n % 2)) img.push_back({8'($urandom), 2'b00});
            end else if (pick < 89) begin
               img.push_back({8'd0, 2'b00});
               img.push_back({ESC_END_OF_BITMAP, 2'b00});
               repeat ($urandom_range(0, 3)) img.push_back({8'($urandom), 2'b00});
               break;
            end else if (pick < 95) begin
               img.push_back({8'($urandom), 2'b00});
            end else begin
               // Cut the image short wherever the parser happens to be.
               break;
            end
         end
      end
      if (img.size() == 0 || $urandom_range(0, 1) == 1) img.push_back({8'($urandom), 2'b00});
      img[img.size() - 1].fin = 1'b1;
      img[0].hold = hold_first;
      foreach (img[i]) stream_bytes.push_back(img[i]);
      bytes_queued += img.size();
      images_queued++;
   endtask

   task automatic queue_random_images(input int target);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < target) queue_image(images_queued % 8 == 3);
   endtask

   task automatic drain_stream();
      while (stream_bytes.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [12:0] w, h;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_settings();
      @(negedge clock);

      // Reset settings: 256 by 256, bottom-up.
      push_code(8'd255, 1'b0);
      push_code(8'h00, 1'b0);
      push_code(8'd2, 1'b0);              // only one pixel of room left on the row
      push_code(8'hFF, 1'b0);
      push_code(8'd0, 1'b0);
      push_code(ESC_END_OF_LINE, 1'b0);
      push_code(8'd0, 1'b0);
      push_code(8'd3, 1'b0);              // odd literal run, so a pad byte follows
      push_code(8'hAA, 1'b0);
      push_code(8'h55, 1'b0);
      push_code(8'h0F, 1'b0);
      push_code(8'h00, 1'b0);
      push_code(8'd0, 1'b0);
      push_code(ESC_DELTA, 1'b0);
      push_code(8'd240, 1'b0);
      push_code(8'd1, 1'b0);
      push_code(8'd3, 1'b0);
      push_code(8'h99, 1'b0);
      push_code(8'd0, 1'b0);
      push_code(ESC_END_OF_BITMAP, 1'b0);
      push_code(8'h37, 1'b0);             // discarded after the end of the bitmap
      push_code(8'h80, 1'b1);
      push_code(8'd0, 1'b0);
      push_code(ESC_DELTA, 1'b0);
      push_code(8'd5, 1'b1);              // final byte inside a delta
      push_code(8'd6, 1'b0);
      push_code(8'h42, 1'b1);             // final byte that also carries a run
      queue_random_images(60);
      drain_stream();

      for (int p = 1; p <= 8; p++) begin
         case (p)
            1: apply_settings(13'd1, 13'd1, 1'b0);
            2: apply_settings(13'd4096, 13'd4096, 1'b1);
            3: apply_settings(13'd0, 13'd3, 1'b1);
            4: apply_settings(13'd8191, 13'd0, 1'b0);
            5: apply_settings(13'd4097, 13'd8191, 1'b1);
            default: begin
               w = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8191)
                                                   : $urandom_range(1, 48));
               h = 13'($urandom_range(1, 6));
               apply_settings(w, h, 1'($urandom_range(0, 1)));
            end
         endcase
         @(negedge clock);
         if (p == 2) begin
            // Push the column cursor to its ceiling and past it.
            repeat (258) begin
               push_code(8'd0, 1'b0);
               push_code(ESC_DELTA, 1'b0);
               push_code(8'd255, 1'b0);
               push_code(8'd0, 1'b0);
            end
            push_code(8'd0, 1'b0);
            push_code(8'd3, 1'b0);
            repeat (4) push_code(8'($urandom), 1'b0);
            push_code(8'd9, 1'b0);
            push_code(8'h5A, 1'b0);
            push_code(8'd0, 1'b0);
            push_code(ESC_END_OF_LINE, 1'b0);
            push_code(8'd4, 1'b0);
            push_code(8'h21, 1'b1);
         end
         queue_random_images(25);
         drain_stream();
      end

      $display("Sent %0d coded bytes in %0d images under %0d register settings.",
               bytes_sent, images_queued, settings_used);
      $display("Checked %0d results (%0d pixel runs); sender held for an empty pipeline %0d times.",
               results_seen, runs_seen, holds_done);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Mismatches: %0d", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d results still expected.", expected_writes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rle8bd_pkg.sv
hw/rtl/rle8bd_csr.sv
hw/rtl/rle8bd_parse.sv
hw/rtl/rle8bd_out.sv
hw/rtl/rle8_bitmap_decoder_top.sv
tb/tb_top.sv
